FILE: rtl/core/rsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types, codes and constants of the reflectance sort queue controller.
// ----------------------------------------------------------------------------
package rsq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [10:0] ALUM_LIMIT_RST  = 11'd300;
  localparam logic [10:0] STEEL_LIMIT_RST = 11'd800;
  localparam logic [10:0] WHITE_LIMIT_RST = 11'd920;
  localparam logic [7:0]  QTURN_RST       = 8'd50;
  localparam logic [10:0] MIN_REFLECT_RST = 11'd1024;

  localparam logic [1:0] REG_ALUM_LIMIT  = 2'd0;
  localparam logic [1:0] REG_STEEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_WHITE_LIMIT = 2'd2;
  localparam logic [1:0] REG_QTURN       = 2'd3;

  typedef enum logic [1:0] {
    CLS_BLACK = 2'd0,
    CLS_STEEL = 2'd1,
    CLS_WHITE = 2'd2,
    CLS_ALUM  = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_END    = 2'd2,
    OP_GATE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [10:0] alum_limit;
    logic [10:0] steel_limit;
    logic [10:0] white_limit;
    logic [7:0]  quarter_turn_steps;
  } cfg_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    class_t cls;
  } queue_req_t;

  typedef struct packed {
    class_t head;
    class_t next;
    logic   empty;
    logic   multi;
  } queue_stat_t;

  typedef struct packed {
    logic [8:0] steps;
    logic       cw;
  } turn_t;

  typedef struct packed {
    logic [1:0]  item_class;
    logic        item_valid;
    logic [8:0]  first_turn_steps;
    logic        first_turn_cw;
    logic [8:0]  second_turn_steps;
    logic        second_turn_cw;
    logic [1:0]  tray_position;
    logic [6:0]  queue_count;
    logic [15:0] black_total;
    logic [15:0] steel_total;
    logic [15:0] white_total;
    logic [15:0] alum_total;
  } out_payload_t;

  function automatic turn_t turn_calc(logic [1:0] from, class_t target, logic [7:0] qts);
    logic [1:0] d;
    turn_t      t;
    d = from - 2'(target);
    t = '0;
    case (d)
      2'd1: begin
        t.steps = {1'b0, qts};
        t.cw    = 1'b1;
      end
      2'd2: begin
        t.steps = {qts, 1'b0};
        t.cw    = 1'b1;
      end
      2'd3: begin
        t.steps = {1'b0, qts};
        t.cw    = 1'b0;
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/rsq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_in_if / rsq_out_if
// Valid/ready channels for events in and step results out.
// ----------------------------------------------------------------------------
interface rsq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [9:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface rsq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_class;
  logic        item_valid;
  logic [8:0]  first_turn_steps;
  logic        first_turn_cw;
  logic [8:0]  second_turn_steps;
  logic        second_turn_cw;
  logic [1:0]  tray_position;
  logic [6:0]  queue_count;
  logic [15:0] black_total;
  logic [15:0] steel_total;
  logic [15:0] white_total;
  logic [15:0] alum_total;

  modport source (
    output valid, input ready,
    output item_class, output item_valid, output first_turn_steps, output first_turn_cw,
    output second_turn_steps, output second_turn_cw, output tray_position,
    output queue_count, output black_total, output steel_total, output white_total,
    output alum_total
  );
  modport sink (
    input valid, output ready,
    input item_class, input item_valid, input first_turn_steps, input first_turn_cw,
    input second_turn_steps, input second_turn_cw, input tray_position,
    input queue_count, input black_total, input steel_total, input white_total,
    input alum_total
  );
endinterface

FILE: rtl/core/rsq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_cfg
// APB register bank for the class thresholds and the quarter turn step count.
// ----------------------------------------------------------------------------
module rsq_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rsq_pkg::cfg_t cfg
);

  rsq_pkg::cfg_t cfg_r;
  rsq_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        rsq_pkg::REG_ALUM_LIMIT:  cfg_nxt.alum_limit         = pwdata[10:0];
        rsq_pkg::REG_STEEL_LIMIT: cfg_nxt.steel_limit        = pwdata[10:0];
        rsq_pkg::REG_WHITE_LIMIT: cfg_nxt.white_limit        = pwdata[10:0];
        rsq_pkg::REG_QTURN:       cfg_nxt.quarter_turn_steps = pwdata[7:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rsq_pkg::REG_ALUM_LIMIT:  prdata = {21'd0, cfg_r.alum_limit};
      rsq_pkg::REG_STEEL_LIMIT: prdata = {21'd0, cfg_r.steel_limit};
      rsq_pkg::REG_WHITE_LIMIT: prdata = {21'd0, cfg_r.white_limit};
      rsq_pkg::REG_QTURN:       prdata = {24'd0, cfg_r.quarter_turn_steps};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alum_limit         <= rsq_pkg::ALUM_LIMIT_RST;
      cfg_r.steel_limit        <= rsq_pkg::STEEL_LIMIT_RST;
      cfg_r.white_limit        <= rsq_pkg::WHITE_LIMIT_RST;
      cfg_r.quarter_turn_steps <= rsq_pkg::QTURN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/rsq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_cell
// One slot of the class queue: loads on a push to its slot, takes its upper
// neighbour's class on a pop.
// ----------------------------------------------------------------------------
module rsq_cell #(
  parameter int FILL_W = 7,
  parameter int IDX    = 0
) (
  input  logic              clk,
  input  logic [FILL_W-1:0] fill,
  input  logic              push,
  input  logic              pop,
  input  rsq_pkg::class_t   push_cls,
  input  rsq_pkg::class_t   upper_cls,
  output rsq_pkg::class_t   cls
);

  rsq_pkg::class_t cls_r;
  rsq_pkg::class_t cls_nxt;

  assign cls = cls_r;

  always_comb begin
    cls_nxt = cls_r;
    if (pop) begin
      cls_nxt = upper_cls;
    end else if (push && (fill == FILL_W'(IDX))) begin
      cls_nxt = push_cls;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

endmodule

FILE: rtl/core/rsq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_queue
// Class queue built as a chain of cells; the head is always in the first cell.
// ----------------------------------------------------------------------------
module rsq_queue #(
  parameter int QUEUE_DEPTH = rsq_pkg::QUEUE_DEPTH_DEF,
  parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsq_pkg::queue_req_t  req,
  output rsq_pkg::queue_stat_t stat,
  output logic [FILL_W-1:0]    fill_nxt
);

  logic [FILL_W-1:0] fill_r;
  logic              push_ok;
  logic              pop_ok;
  rsq_pkg::class_t   cells [QUEUE_DEPTH];

  assign push_ok = req.push && (fill_r != FILL_W'(QUEUE_DEPTH));
  assign pop_ok  = req.pop && (fill_r != '0);

  always_comb begin
    fill_nxt = fill_r;
    if (push_ok) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop_ok) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rsq_pkg::class_t upper;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign upper = rsq_pkg::CLS_BLACK;
    end else begin : g_mid
      assign upper = cells[i+1];
    end
    rsq_cell #(
      .FILL_W (FILL_W),
      .IDX    (i)
    ) u_cell (
      .clk       (clk),
      .fill      (fill_r),
      .push      (push_ok),
      .pop       (pop_ok),
      .push_cls  (req.cls),
      .upper_cls (upper),
      .cls       (cells[i])
    );
  end

  assign stat.head  = cells[0];
  assign stat.next  = cells[1];
  assign stat.empty = (fill_r == '0);
  assign stat.multi = (fill_r > FILL_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: rtl/core/reflectance_sort_queue_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflectance_sort_queue_controller
// Event-driven sorter control: reflectance minimum, class queue, tray turns.
//
// Events arrive on in_ch (operation, sample) with a valid/ready transfer.
// Each accepted event yields exactly one result on out_ch in the next cycle:
// class, turns for the tray, tray position, queue fill and per-class totals.
// One event per cycle is taken unless out_ch stalls; the whole update of the
// minimum, the queue cells, the tray and the totals is done in the cycle of
// the transfer and lands in the output register.
// in_ch.ready is high while the output register is empty or is being read
// in the same cycle, so a stalled receiver holds the result and stops input
// after one event; nothing is lost or repeated.
// Thresholds and the quarter turn step count are APB registers at byte
// addresses 0, 4, 8 and 12, written by the user only while the block is idle;
// the block does not enforce this. Reset (rst_n low, synchronous) empties the
// queue, homes the tray on the black bin, clears the totals, sets the minimum
// to 1024 and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module reflectance_sort_queue_controller #(
  parameter int QUEUE_DEPTH = rsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rsq_in_if.sink      in_ch,
  rsq_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  rsq_pkg::cfg_t        cfg;
  rsq_pkg::queue_req_t  qreq;
  rsq_pkg::queue_stat_t qstat;
  logic [FILL_W-1:0]    fill_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  rsq_pkg::out_payload_t out_r;
  rsq_pkg::out_payload_t out_nxt;
  logic [10:0]          min_r;
  logic [10:0]          min_nxt;
  logic [1:0]           tray_r;
  logic [1:0]           tray_nxt;
  logic [15:0]          cnt_r   [4];
  logic [15:0]          cnt_nxt [4];
  logic                 xfer_in;
  rsq_pkg::op_t         op;
  rsq_pkg::class_t      end_cls;
  rsq_pkg::turn_t       t1;
  rsq_pkg::turn_t       t2;

  rsq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FILL_W      (FILL_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (qreq),
    .stat     (qstat),
    .fill_nxt (fill_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer_in     = in_ch.valid && in_ch.ready;
  assign op          = rsq_pkg::op_t'(in_ch.operation);

  always_comb begin
    if (min_r < cfg.alum_limit) begin
      end_cls = rsq_pkg::CLS_ALUM;
    end else if (min_r < cfg.steel_limit) begin
      end_cls = rsq_pkg::CLS_STEEL;
    end else if (min_r < cfg.white_limit) begin
      end_cls = rsq_pkg::CLS_WHITE;
    end else begin
      end_cls = rsq_pkg::CLS_BLACK;
    end
  end

  assign t1 = rsq_pkg::turn_calc(tray_r, qstat.head, cfg.quarter_turn_steps);
  assign t2 = rsq_pkg::turn_calc(qstat.head, qstat.next, cfg.quarter_turn_steps);

  always_comb begin
    qreq.push = 1'b0;
    qreq.pop  = 1'b0;
    qreq.cls  = end_cls;
    min_nxt   = min_r;
    tray_nxt  = tray_r;
    for (int k = 0; k < 4; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    out_nxt            = '0;
    out_nxt.item_class = rsq_pkg::CLS_BLACK;

    if (xfer_in) begin
      case (op)
        rsq_pkg::OP_START: begin
          min_nxt = rsq_pkg::MIN_REFLECT_RST;
        end
        rsq_pkg::OP_SAMPLE: begin
          if ({1'b0, in_ch.sample} < min_r) begin
            min_nxt = {1'b0, in_ch.sample};
          end
        end
        rsq_pkg::OP_END: begin
          qreq.push          = 1'b1;
          out_nxt.item_class = end_cls;
          out_nxt.item_valid = 1'b1;
        end
        rsq_pkg::OP_GATE: begin
          if (!qstat.empty) begin
            qreq.pop = 1'b1;
            if (cnt_r[qstat.head] != 16'hFFFF) begin
              cnt_nxt[qstat.head] = cnt_r[qstat.head] + 16'd1;
            end
            out_nxt.item_class       = qstat.head;
            out_nxt.item_valid       = 1'b1;
            out_nxt.first_turn_steps = t1.steps;
            out_nxt.first_turn_cw    = t1.cw;
            tray_nxt                 = qstat.head;
            if (qstat.multi) begin
              out_nxt.second_turn_steps = t2.steps;
              out_nxt.second_turn_cw    = t2.cw;
              tray_nxt                  = qstat.next;
            end
          end
        end
        default: min_nxt = min_r;
      endcase
    end

    out_nxt.tray_position = tray_nxt;
    out_nxt.queue_count   = 7'(fill_nxt);
    out_nxt.black_total   = cnt_nxt[rsq_pkg::CLS_BLACK];
    out_nxt.steel_total   = cnt_nxt[rsq_pkg::CLS_STEEL];
    out_nxt.white_total   = cnt_nxt[rsq_pkg::CLS_WHITE];
    out_nxt.alum_total    = cnt_nxt[rsq_pkg::CLS_ALUM];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (xfer_in) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      min_r       <= rsq_pkg::MIN_REFLECT_RST;
      tray_r      <= rsq_pkg::CLS_BLACK;
      for (int k = 0; k < 4; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      tray_r      <= tray_nxt;
      for (int k = 0; k < 4; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_in) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.item_class        = out_r.item_class;
  assign out_ch.item_valid        = out_r.item_valid;
  assign out_ch.first_turn_steps  = out_r.first_turn_steps;
  assign out_ch.first_turn_cw     = out_r.first_turn_cw;
  assign out_ch.second_turn_steps = out_r.second_turn_steps;
  assign out_ch.second_turn_cw    = out_r.second_turn_cw;
  assign out_ch.tray_position     = out_r.tray_position;
  assign out_ch.queue_count       = out_r.queue_count;
  assign out_ch.black_total       = out_r.black_total;
  assign out_ch.steel_total       = out_r.steel_total;
  assign out_ch.white_total       = out_r.white_total;
  assign out_ch.alum_total        = out_r.alum_total;

endmodule

FILE: rtl/core/rsq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_checker
// Port-level checks on the sort queue controller, bound to the top level.
// ----------------------------------------------------------------------------
module rsq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_class,
  input logic       item_valid,
  input logic [8:0] first_turn_steps,
  input logic [8:0] second_turn_steps
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(item_class) && $stable(item_valid))
    else $error("stalled result changed");

  // every input transfer is followed by a result
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  // input is taken whenever the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // no item means class code 0 (black) and no turns
  a_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !item_valid |->
      item_class == 2'd0 && first_turn_steps == 9'd0 && second_turn_steps == 9'd0)
    else $error("turn or class without item");

endmodule

bind reflectance_sort_queue_controller rsq_checker u_rsq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .item_class        (out_ch.item_class),
  .item_valid        (out_ch.item_valid),
  .first_turn_steps  (out_ch.first_turn_steps),
  .second_turn_steps (out_ch.second_turn_steps)
);
